FILE: hdl/rvde_pkg.sv
`default_nettype none
package rvde_pkg;

  localparam int unsigned RegCount = 32;
  localparam int unsigned RegAw = $clog2(RegCount);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw = $clog2(QueueDepth);
  localparam int unsigned QueueCw = $clog2(QueueDepth + 1);
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCw = $clog2(DivSteps);

  localparam logic [31:0] ResetVector = 32'h8000_0000;

  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcJal    = 7'h6f;
  localparam logic [6:0] OpcJalr   = 7'h67;
  localparam logic [6:0] OpcBranch = 7'h63;
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcOpImm  = 7'h13;
  localparam logic [6:0] OpcOp     = 7'h33;
  localparam logic [6:0] OpcSystem = 7'h73;

  localparam logic [31:0] InsEcall  = 32'h0000_0073;
  localparam logic [31:0] InsEbreak = 32'h0010_0073;
  localparam logic [31:0] InsMret   = 32'h3020_0073;

  localparam logic [6:0] F7Base = 7'h00;
  localparam logic [6:0] F7Muldiv = 7'h01;
  localparam logic [6:0] F7Alt = 7'h20;

  localparam logic [2:0] F3Add  = 3'd0;
  localparam logic [2:0] F3Sll  = 3'd1;
  localparam logic [2:0] F3Slt  = 3'd2;
  localparam logic [2:0] F3Sltu = 3'd3;
  localparam logic [2:0] F3Xor  = 3'd4;
  localparam logic [2:0] F3Sr   = 3'd5;
  localparam logic [2:0] F3Or   = 3'd6;
  localparam logic [2:0] F3And  = 3'd7;

  localparam logic [2:0] F3Beq  = 3'd0;
  localparam logic [2:0] F3Bne  = 3'd1;
  localparam logic [2:0] F3Blt  = 3'd4;
  localparam logic [2:0] F3Bge  = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6;
  localparam logic [2:0] F3Bgeu = 3'd7;

  localparam logic [2:0] F3Lb  = 3'd0;
  localparam logic [2:0] F3Lh  = 3'd1;
  localparam logic [2:0] F3Lw  = 3'd2;
  localparam logic [2:0] F3Lbu = 3'd4;
  localparam logic [2:0] F3Lhu = 3'd5;
  localparam logic [2:0] F3Sw  = 3'd2;

  localparam logic [2:0] F3Mul    = 3'd0;
  localparam logic [2:0] F3Mulh   = 3'd1;
  localparam logic [2:0] F3Mulhsu = 3'd2;

  localparam logic [2:0] F3Csrrw = 3'd1;
  localparam logic [2:0] F3Csrrs = 3'd2;

  localparam logic [11:0] CsrMtvec   = 12'h305;
  localparam logic [11:0] CsrMepc    = 12'h341;
  localparam logic [11:0] CsrMcause  = 12'h342;
  localparam logic [11:0] CsrMstatus = 12'h300;

  localparam logic [4:0] RegA0 = 5'd10;
  localparam logic [4:0] RegA7 = 5'd17;

  localparam logic [31:0] CauseEcallM = 32'd11;
  localparam logic [31:0] CauseEcallU = 32'd8;

  localparam logic [1:0] MemNone  = 2'd0;
  localparam logic [1:0] MemRead  = 2'd1;
  localparam logic [1:0] MemWrite = 2'd2;

  localparam logic [2:0] StatusOk         = 3'd0;
  localparam logic [2:0] StatusEbreak     = 3'd1;
  localparam logic [2:0] StatusIllegal    = 3'd2;
  localparam logic [2:0] StatusEcall      = 3'd3;
  localparam logic [2:0] StatusBadCsr     = 3'd4;
  localparam logic [2:0] StatusLoadDone   = 3'd5;
  localparam logic [2:0] StatusOutOfOrder = 3'd6;

  typedef enum logic [3:0] {
    CL_LUI, CL_AUIPC, CL_JAL, CL_JALR, CL_BRANCH, CL_LOAD, CL_STORE, CL_ALU,
    CL_MUL, CL_DIV, CL_ECALL, CL_EBREAK, CL_MRET, CL_CSR, CL_BAD_CSR, CL_ILLEGAL
  } class_e;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR, ALU_SRL, ALU_SRA,
    ALU_OR, ALU_AND
  } alu_op_e;

  typedef enum logic [1:0] {
    CSR_MTVEC, CSR_MEPC, CSR_MCAUSE, CSR_MSTATUS
  } csr_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_DONE
  } state_e;

  typedef struct packed {
    logic        action;
    logic [31:0] instruction;
    logic [31:0] load_data;
  } in_t;

  typedef struct packed {
    logic [31:0] exec_pc;
    logic [31:0] next_pc;
    logic [1:0]  mem_request;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_write;
    logic [2:0]  status;
    logic [31:0] trap_value;
  } out_t;

  typedef struct packed {
    logic        action;
    class_e      cls;
    alu_op_e     alu_op;
    logic        use_imm;
    csr_e        csr_sel;
    logic [31:0] ins;
    logic [31:0] imm;
    logic [31:0] load_data;
    logic [4:0]  ra1;
    logic [4:0]  ra2;
  } dec_t;

  function automatic logic reg_ok(logic [4:0] idx);
    return (idx != 5'd0) && (32'(idx) < RegCount);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rvde_ram.sv
`default_nettype none
module rvde_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule
`default_nettype wire

FILE: hdl/rvde_front.sv
`default_nettype none
module rvde_front (
  input  wire logic            in_valid_i,
  input  wire rvde_pkg::in_t   in_beat_i,
  output logic                 in_stall_o,
  input  wire logic            q_full_i,
  output logic                 push_o,
  output rvde_pkg::dec_t       dec_o
);

  logic [31:0] ins;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;

  assign ins = in_beat_i.instruction;
  assign opc = ins[6:0];
  assign f3 = ins[14:12];
  assign f7 = ins[31:25];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign imm_u = {ins[31:12], 12'b0};
  assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};

  assign in_stall_o = q_full_i;
  assign push_o = in_valid_i && !q_full_i;

  always_comb begin
    dec_o = '0;
    dec_o.action = in_beat_i.action;
    dec_o.ins = ins;
    dec_o.load_data = in_beat_i.load_data;
    dec_o.cls = rvde_pkg::CL_ILLEGAL;
    dec_o.alu_op = rvde_pkg::ALU_ADD;
    dec_o.use_imm = 1'b0;
    dec_o.csr_sel = rvde_pkg::CSR_MTVEC;
    dec_o.imm = imm_i;
    dec_o.ra1 = ins[19:15];
    dec_o.ra2 = ins[24:20];
    case (opc)
      rvde_pkg::OpcLui: begin
        dec_o.cls = rvde_pkg::CL_LUI;
        dec_o.imm = imm_u;
      end
      rvde_pkg::OpcAuipc: begin
        dec_o.cls = rvde_pkg::CL_AUIPC;
        dec_o.imm = imm_u;
      end
      rvde_pkg::OpcJal: begin
        dec_o.cls = rvde_pkg::CL_JAL;
        dec_o.imm = imm_j;
      end
      rvde_pkg::OpcJalr: begin
        if (f3 == rvde_pkg::F3Add) begin
          dec_o.cls = rvde_pkg::CL_JALR;
        end
      end
      rvde_pkg::OpcBranch: begin
        dec_o.imm = imm_b;
        if (f3 inside {rvde_pkg::F3Beq, rvde_pkg::F3Bne, rvde_pkg::F3Blt,
                       rvde_pkg::F3Bge, rvde_pkg::F3Bltu, rvde_pkg::F3Bgeu}) begin
          dec_o.cls = rvde_pkg::CL_BRANCH;
        end
      end
      rvde_pkg::OpcLoad: begin
        if (f3 inside {rvde_pkg::F3Lb, rvde_pkg::F3Lh, rvde_pkg::F3Lw,
                       rvde_pkg::F3Lbu, rvde_pkg::F3Lhu}) begin
          dec_o.cls = rvde_pkg::CL_LOAD;
        end
      end
      rvde_pkg::OpcStore: begin
        dec_o.imm = imm_s;
        if (f3 <= rvde_pkg::F3Sw) begin
          dec_o.cls = rvde_pkg::CL_STORE;
        end
      end
      rvde_pkg::OpcOpImm: begin
        dec_o.use_imm = 1'b1;
        dec_o.cls = rvde_pkg::CL_ALU;
        case (f3)
          rvde_pkg::F3Add:  dec_o.alu_op = rvde_pkg::ALU_ADD;
          rvde_pkg::F3Slt:  dec_o.alu_op = rvde_pkg::ALU_SLT;
          rvde_pkg::F3Sltu: dec_o.alu_op = rvde_pkg::ALU_SLTU;
          rvde_pkg::F3Xor:  dec_o.alu_op = rvde_pkg::ALU_XOR;
          rvde_pkg::F3Or:   dec_o.alu_op = rvde_pkg::ALU_OR;
          rvde_pkg::F3And:  dec_o.alu_op = rvde_pkg::ALU_AND;
          rvde_pkg::F3Sll: begin
            dec_o.alu_op = rvde_pkg::ALU_SLL;
            if (f7 != rvde_pkg::F7Base) begin
              dec_o.cls = rvde_pkg::CL_ILLEGAL;
            end
          end
          default: begin
            if (f7 == rvde_pkg::F7Base) begin
              dec_o.alu_op = rvde_pkg::ALU_SRL;
            end else if (f7 == rvde_pkg::F7Alt) begin
              dec_o.alu_op = rvde_pkg::ALU_SRA;
            end else begin
              dec_o.cls = rvde_pkg::CL_ILLEGAL;
            end
          end
        endcase
      end
      rvde_pkg::OpcOp: begin
        if (f7 == rvde_pkg::F7Muldiv) begin
          dec_o.cls = f3[2] ? rvde_pkg::CL_DIV : rvde_pkg::CL_MUL;
        end else if (f7 == rvde_pkg::F7Base) begin
          dec_o.cls = rvde_pkg::CL_ALU;
          case (f3)
            rvde_pkg::F3Add:  dec_o.alu_op = rvde_pkg::ALU_ADD;
            rvde_pkg::F3Sll:  dec_o.alu_op = rvde_pkg::ALU_SLL;
            rvde_pkg::F3Slt:  dec_o.alu_op = rvde_pkg::ALU_SLT;
            rvde_pkg::F3Sltu: dec_o.alu_op = rvde_pkg::ALU_SLTU;
            rvde_pkg::F3Xor:  dec_o.alu_op = rvde_pkg::ALU_XOR;
            rvde_pkg::F3Sr:   dec_o.alu_op = rvde_pkg::ALU_SRL;
            rvde_pkg::F3Or:   dec_o.alu_op = rvde_pkg::ALU_OR;
            default:          dec_o.alu_op = rvde_pkg::ALU_AND;
          endcase
        end else if (f7 == rvde_pkg::F7Alt && f3 == rvde_pkg::F3Add) begin
          dec_o.cls = rvde_pkg::CL_ALU;
          dec_o.alu_op = rvde_pkg::ALU_SUB;
        end else if (f7 == rvde_pkg::F7Alt && f3 == rvde_pkg::F3Sr) begin
          dec_o.cls = rvde_pkg::CL_ALU;
          dec_o.alu_op = rvde_pkg::ALU_SRA;
        end
      end
      rvde_pkg::OpcSystem: begin
        if (ins == rvde_pkg::InsEcall) begin
          dec_o.cls = rvde_pkg::CL_ECALL;
          dec_o.ra1 = rvde_pkg::RegA7;
        end else if (ins == rvde_pkg::InsEbreak) begin
          dec_o.cls = rvde_pkg::CL_EBREAK;
          dec_o.ra1 = rvde_pkg::RegA0;
        end else if (ins == rvde_pkg::InsMret) begin
          dec_o.cls = rvde_pkg::CL_MRET;
        end else if (f3 == rvde_pkg::F3Csrrw || f3 == rvde_pkg::F3Csrrs) begin
          dec_o.cls = rvde_pkg::CL_CSR;
          case (ins[31:20])
            rvde_pkg::CsrMtvec:   dec_o.csr_sel = rvde_pkg::CSR_MTVEC;
            rvde_pkg::CsrMepc:    dec_o.csr_sel = rvde_pkg::CSR_MEPC;
            rvde_pkg::CsrMcause:  dec_o.csr_sel = rvde_pkg::CSR_MCAUSE;
            rvde_pkg::CsrMstatus: dec_o.csr_sel = rvde_pkg::CSR_MSTATUS;
            default:              dec_o.cls = rvde_pkg::CL_BAD_CSR;
          endcase
        end
      end
      default: dec_o.cls = rvde_pkg::CL_ILLEGAL;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/rvde_queue.sv
`default_nettype none
module rvde_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rvde_pkg::dec_t din_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output rvde_pkg::dec_t      dout_o
);

  rvde_pkg::dec_t                   mem_q [rvde_pkg::QueueDepth];
  logic [rvde_pkg::QueueAw-1:0]     wptr_q, wptr_d;
  logic [rvde_pkg::QueueAw-1:0]     rptr_q, rptr_d;
  logic [rvde_pkg::QueueCw-1:0]     count_q, count_d;

  assign full_o = (count_q == rvde_pkg::QueueCw'(rvde_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign dout_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == rvde_pkg::QueueAw'(rvde_pkg::QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == rvde_pkg::QueueAw'(rvde_pkg::QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      count_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= din_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rvde_back.sv
`default_nettype none
module rvde_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [31:0]    reset_vector_i,
  input  wire logic           q_empty_i,
  input  wire rvde_pkg::dec_t q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rvde_pkg::out_t      out_beat_o
);

  rvde_pkg::state_e state_q, state_d;
  rvde_pkg::dec_t   item_q;
  rvde_pkg::out_t   out_q, out_d;

  logic [31:0] pc_q, mtvec_q, mepc_q, mcause_q, mstatus_q;
  logic        boot_q;
  logic        load_pending_q;
  logic [4:0]  pend_dest_q;
  logic [2:0]  pend_kind_q;
  logic [rvde_pkg::RegCount-1:0] valid_q;
  logic        out_valid_q;

  logic [31:0] a_q, b_q;
  logic [63:0] prod_q;
  logic [31:0] div_quo_q, div_rem_q, div_den_q;
  logic [rvde_pkg::DivCw-1:0] div_cnt_q;

  logic [31:0] ram_a, ram_b, rd_a, rd_b;
  logic        out_free, commit;

  logic [2:0]  f3;
  logic        div_signed;
  logic        na_raw, nb_raw;
  logic [65:0] prod_full;
  logic [32:0] rem_sh;
  logic [33:0] div_diff;

  logic [31:0] opb, alu_val, md_val, val, npc, csr_old, csr_new;
  logic        take, wr, dest_write, csr_we, ecall_we;
  logic [4:0]  wr_idx;
  logic        set_pending, clear_pending;

  rvde_ram #(
    .Width (32),
    .Depth (rvde_pkg::RegCount)
  ) u_regfile (
    .clk_i     (clk_i),
    .we_i      (commit && dest_write),
    .waddr_i   (wr_idx[rvde_pkg::RegAw-1:0]),
    .wdata_i   (val),
    .raddr_a_i (q_item_i.ra1[rvde_pkg::RegAw-1:0]),
    .raddr_b_i (q_item_i.ra2[rvde_pkg::RegAw-1:0]),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  assign rd_a = (rvde_pkg::reg_ok(item_q.ra1) && valid_q[item_q.ra1[rvde_pkg::RegAw-1:0]])
                ? ram_a : '0;
  assign rd_b = (rvde_pkg::reg_ok(item_q.ra2) && valid_q[item_q.ra2[rvde_pkg::RegAw-1:0]])
                ? ram_b : '0;

  assign f3 = item_q.ins[14:12];
  assign div_signed = !item_q.ins[12];
  assign na_raw = div_signed && rd_a[31];
  assign nb_raw = div_signed && rd_b[31];

  always_comb begin
    logic sa, sb;
    sa = (f3 == rvde_pkg::F3Mulh) || (f3 == rvde_pkg::F3Mulhsu);
    sb = (f3 == rvde_pkg::F3Mulh);
    prod_full = $signed({sa && a_q[31], a_q}) * $signed({sb && b_q[31], b_q});
  end

  assign rem_sh = {div_rem_q, div_quo_q[31]};
  assign div_diff = {1'b0, rem_sh} - {2'b0, div_den_q};

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rvde_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = rvde_pkg::ST_READ;
        end
      end
      rvde_pkg::ST_READ: begin
        if (!item_q.action && item_q.cls == rvde_pkg::CL_MUL) begin
          state_d = rvde_pkg::ST_MUL;
        end else if (!item_q.action && item_q.cls == rvde_pkg::CL_DIV) begin
          state_d = rvde_pkg::ST_DIV;
        end else begin
          state_d = rvde_pkg::ST_DONE;
        end
      end
      rvde_pkg::ST_MUL: state_d = rvde_pkg::ST_DONE;
      rvde_pkg::ST_DIV: begin
        if (div_cnt_q == rvde_pkg::DivCw'(rvde_pkg::DivSteps - 1)) begin
          state_d = rvde_pkg::ST_DONE;
        end
      end
      rvde_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rvde_pkg::ST_IDLE;
        end
      end
      default: state_d = rvde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = (state_q == rvde_pkg::ST_IDLE) && !q_empty_i;
    commit = (state_q == rvde_pkg::ST_DONE) && out_free;
  end

  always_comb begin
    logic [31:0] q_res, r_res;
    q_res = (div_signed && (a_q[31] ^ b_q[31])) ? (32'd0 - div_quo_q) : div_quo_q;
    r_res = (div_signed && a_q[31]) ? (32'd0 - div_rem_q) : div_rem_q;
    if (item_q.cls == rvde_pkg::CL_MUL) begin
      md_val = (f3 == rvde_pkg::F3Mul) ? prod_q[31:0] : prod_q[63:32];
    end else if (b_q == '0) begin
      md_val = item_q.ins[13] ? a_q : '1;
    end else begin
      md_val = item_q.ins[13] ? r_res : q_res;
    end
  end

  always_comb begin
    opb = item_q.use_imm ? item_q.imm : b_q;
    case (item_q.alu_op)
      rvde_pkg::ALU_ADD:  alu_val = a_q + opb;
      rvde_pkg::ALU_SUB:  alu_val = a_q - opb;
      rvde_pkg::ALU_SLL:  alu_val = a_q << opb[4:0];
      rvde_pkg::ALU_SLT:  alu_val = {31'b0, $signed(a_q) < $signed(opb)};
      rvde_pkg::ALU_SLTU: alu_val = {31'b0, a_q < opb};
      rvde_pkg::ALU_XOR:  alu_val = a_q ^ opb;
      rvde_pkg::ALU_SRL:  alu_val = a_q >> opb[4:0];
      rvde_pkg::ALU_SRA:  alu_val = $unsigned($signed(a_q) >>> opb[4:0]);
      rvde_pkg::ALU_OR:   alu_val = a_q | opb;
      default:            alu_val = a_q & opb;
    endcase
    case (f3)
      rvde_pkg::F3Beq:  take = (a_q == b_q);
      rvde_pkg::F3Bne:  take = (a_q != b_q);
      rvde_pkg::F3Blt:  take = $signed(a_q) < $signed(b_q);
      rvde_pkg::F3Bge:  take = $signed(a_q) >= $signed(b_q);
      rvde_pkg::F3Bltu: take = (a_q < b_q);
      rvde_pkg::F3Bgeu: take = (a_q >= b_q);
      default:          take = 1'b0;
    endcase
    case (item_q.csr_sel)
      rvde_pkg::CSR_MTVEC:  csr_old = mtvec_q;
      rvde_pkg::CSR_MEPC:   csr_old = mepc_q;
      rvde_pkg::CSR_MCAUSE: csr_old = mcause_q;
      default:              csr_old = mstatus_q;
    endcase
    csr_new = (f3 == rvde_pkg::F3Csrrw) ? a_q : (csr_old | a_q);
  end

  always_comb begin
    out_d = '0;
    out_d.exec_pc = pc_q;
    out_d.status = rvde_pkg::StatusOk;
    npc = pc_q + 32'd4;
    val = '0;
    wr = 1'b0;
    wr_idx = item_q.ins[11:7];
    csr_we = 1'b0;
    ecall_we = 1'b0;
    set_pending = 1'b0;
    clear_pending = 1'b0;
    if (item_q.action || load_pending_q) begin
      npc = pc_q;
      if (item_q.action && load_pending_q) begin
        clear_pending = 1'b1;
        out_d.exec_pc = pc_q - 32'd4;
        out_d.status = rvde_pkg::StatusLoadDone;
        wr = 1'b1;
        wr_idx = pend_dest_q;
        case (pend_kind_q)
          rvde_pkg::F3Lb:  val = {{24{item_q.load_data[7]}}, item_q.load_data[7:0]};
          rvde_pkg::F3Lh:  val = {{16{item_q.load_data[15]}}, item_q.load_data[15:0]};
          rvde_pkg::F3Lbu: val = {24'b0, item_q.load_data[7:0]};
          rvde_pkg::F3Lhu: val = {16'b0, item_q.load_data[15:0]};
          default:         val = item_q.load_data;
        endcase
      end else begin
        out_d.status = rvde_pkg::StatusOutOfOrder;
      end
    end else begin
      case (item_q.cls)
        rvde_pkg::CL_LUI: begin
          wr = 1'b1;
          val = item_q.imm;
        end
        rvde_pkg::CL_AUIPC: begin
          wr = 1'b1;
          val = pc_q + item_q.imm;
        end
        rvde_pkg::CL_JAL: begin
          wr = 1'b1;
          val = pc_q + 32'd4;
          npc = pc_q + item_q.imm;
        end
        rvde_pkg::CL_JALR: begin
          wr = 1'b1;
          val = pc_q + 32'd4;
          npc = (a_q + item_q.imm) & ~32'd1;
        end
        rvde_pkg::CL_BRANCH: begin
          if (take) begin
            npc = pc_q + item_q.imm;
          end
        end
        rvde_pkg::CL_LOAD: begin
          set_pending = 1'b1;
          out_d.mem_request = rvde_pkg::MemRead;
          out_d.mem_address = a_q + item_q.imm;
          out_d.mem_size = f3[1:0];
        end
        rvde_pkg::CL_STORE: begin
          out_d.mem_request = rvde_pkg::MemWrite;
          out_d.mem_address = a_q + item_q.imm;
          out_d.mem_size = f3[1:0];
          out_d.store_data = b_q;
        end
        rvde_pkg::CL_ALU: begin
          wr = 1'b1;
          val = alu_val;
        end
        rvde_pkg::CL_MUL, rvde_pkg::CL_DIV: begin
          wr = 1'b1;
          val = md_val;
        end
        rvde_pkg::CL_ECALL: begin
          out_d.status = rvde_pkg::StatusEcall;
          ecall_we = 1'b1;
          npc = mtvec_q;
        end
        rvde_pkg::CL_EBREAK: begin
          out_d.status = rvde_pkg::StatusEbreak;
          out_d.trap_value = a_q;
        end
        rvde_pkg::CL_MRET: npc = mepc_q;
        rvde_pkg::CL_CSR: begin
          wr = 1'b1;
          val = csr_old;
          csr_we = 1'b1;
        end
        rvde_pkg::CL_BAD_CSR: begin
          out_d.status = rvde_pkg::StatusBadCsr;
          npc = pc_q;
        end
        default: begin
          out_d.status = rvde_pkg::StatusIllegal;
          npc = pc_q;
        end
      endcase
    end
    dest_write = wr && rvde_pkg::reg_ok(wr_idx);
    out_d.next_pc = npc;
    out_d.dest_write = dest_write;
    out_d.dest_index = dest_write ? wr_idx : '0;
    out_d.dest_value = dest_write ? val : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rvde_pkg::ST_IDLE;
      pc_q <= rvde_pkg::ResetVector;
      boot_q <= 1'b1;
      mtvec_q <= '0;
      mepc_q <= '0;
      mcause_q <= '0;
      mstatus_q <= '0;
      load_pending_q <= 1'b0;
      pend_dest_q <= '0;
      pend_kind_q <= '0;
      valid_q <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      boot_q <= 1'b0;
      if (boot_q) begin
        pc_q <= reset_vector_i;
      end
      if (state_q == rvde_pkg::ST_READ) begin
        div_cnt_q <= '0;
      end else if (state_q == rvde_pkg::ST_DIV) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        pc_q <= npc;
        if (dest_write) begin
          valid_q[wr_idx[rvde_pkg::RegAw-1:0]] <= 1'b1;
        end
        if (set_pending) begin
          load_pending_q <= 1'b1;
          pend_dest_q <= item_q.ins[11:7];
          pend_kind_q <= f3;
        end else if (clear_pending) begin
          load_pending_q <= 1'b0;
        end
        if (ecall_we) begin
          mepc_q <= pc_q;
          mcause_q <= (a_q == '1) ? rvde_pkg::CauseEcallM : rvde_pkg::CauseEcallU;
        end
        if (csr_we) begin
          case (item_q.csr_sel)
            rvde_pkg::CSR_MTVEC:  mtvec_q <= csr_new;
            rvde_pkg::CSR_MEPC:   mepc_q <= csr_new;
            rvde_pkg::CSR_MCAUSE: mcause_q <= csr_new;
            default:              mstatus_q <= csr_new;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    if (state_q == rvde_pkg::ST_READ) begin
      a_q <= rd_a;
      b_q <= rd_b;
      div_quo_q <= na_raw ? (32'd0 - rd_a) : rd_a;
      div_den_q <= nb_raw ? (32'd0 - rd_b) : rd_b;
      div_rem_q <= '0;
    end
    if (state_q == rvde_pkg::ST_MUL) begin
      prod_q <= prod_full[63:0];
    end
    if (state_q == rvde_pkg::ST_DIV) begin
      if (div_diff[33]) begin
        div_rem_q <= rem_sh[31:0];
        div_quo_q <= {div_quo_q[30:0], 1'b0};
      end else begin
        div_rem_q <= div_diff[31:0];
        div_quo_q <= {div_quo_q[30:0], 1'b1};
      end
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  a_div_cnt_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_cnt_q != '0) |-> (state_q == rvde_pkg::ST_DIV))
    else $error("Divider step count is nonzero outside the divide state.");

  a_hold_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rvde_pkg::ST_DONE && out_valid_q && out_stall_i)
      |=> (state_q == rvde_pkg::ST_DONE))
    else $error("A result left the done state while the output register was blocked.");

  a_x0_never_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0])
    else $error("Register x0 was marked as written.");

  a_pop_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == rvde_pkg::ST_READ))
    else $error("A queue pop did not start a register read.");

endmodule
`default_nettype wire

FILE: hdl/rv32im_decode_execute_unit.sv
`default_nettype none
// RV32IM execute unit. Each input beat carries either an instruction word fetched at the
// current program counter (action 0) or the read data of the pending load (action 1), and
// produces exactly one result beat with the next fetch address, any memory request, the
// register write and a status code. A front decoder classifies the beat and places it in a
// two-entry queue, so the input side keeps accepting while the back end executes, until
// the queue fills. The back end handles one beat at a time: a plain instruction passes
// from the queue through register file read, operand capture, then execute and commit
// into the output register; a multiply adds a product step, and a divide or remainder
// runs the divider, one quotient bit per cycle. A result that waits on a stalled output
// holds the back end for as long as the stall lasts.
// Memory is not accessed directly: a load issues a read request and must be followed by a
// data beat before the next instruction. The reset vector register is sampled into the
// program counter once on leaving reset, before any instruction executes.
module rv32im_decode_execute_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [31:0]    cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire rvde_pkg::in_t  in_beat_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rvde_pkg::out_t      out_beat_o
);

  logic [31:0]    reset_vector_q;
  logic           push, q_full, q_empty, q_pop;
  rvde_pkg::dec_t dec, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_vector_q <= rvde_pkg::ResetVector;
    end else if (cfg_we_i) begin
      reset_vector_q <= cfg_wdata_i;
    end
  end

  rvde_front u_front (
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_beat_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .dec_o      (dec)
  );

  rvde_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (dec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .dout_o  (q_item)
  );

  rvde_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .reset_vector_i (reset_vector_q),
    .q_empty_i      (q_empty),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_beat_o     (out_beat_o)
  );

endmodule
`default_nettype wire
